/* design/greedy_identity_sequence_filter_unit_macros.svh */
// Assertion macros for the greedy identity sequence filter.
// Used by the port checker; needs clk_i and rst_ni in scope.
`ifndef GREEDY_IDENTITY_SEQUENCE_FILTER_UNIT_MACROS_SVH
`define GREEDY_IDENTITY_SEQUENCE_FILTER_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define GISF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define GISF_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* design/gisf_pkg.sv */
// Shared constants, types and codes of the greedy identity sequence filter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gisf_pkg;

  localparam int MAX_SEQ_LEN    = 256;
  localparam int MAX_REFERENCES = 1024;
  localparam int MAX_KEPT       = 1024;
  localparam int RESIDUE_BITS   = 5;

  localparam int POS_W      = $clog2(MAX_SEQ_LEN);
  localparam int LEN_W      = $clog2(MAX_SEQ_LEN + 1);
  localparam int REF_ROW_W  = (MAX_REFERENCES > 1) ? $clog2(MAX_REFERENCES) : 1;
  localparam int KEPT_ROW_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CNT_W      = 11;
  localparam int THR_W      = 17;
  localparam int SEQ_W      = 9;
  localparam int MATCH_W    = LEN_W;
  localparam int PROD_W     = THR_W + LEN_W;
  localparam int REF_DEPTH  = MAX_REFERENCES * MAX_SEQ_LEN;
  localparam int KEPT_DEPTH = MAX_KEPT * MAX_SEQ_LEN;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(52429);
  localparam logic [SEQ_W-1:0] SEQ_RESET = SEQ_W'(256);

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_BETWEEN = 2'd0;
  localparam logic [1:0] REG_WITHIN  = 2'd1;
  localparam logic [1:0] REG_SEQ_LEN = 2'd2;

  // Input opcodes
  localparam logic OP_REFERENCE = 1'b0;
  localparam logic OP_CANDIDATE = 1'b1;

  typedef enum logic [1:0] {
    VERDICT_KEPT      = 2'd0,
    VERDICT_NEAR_REF  = 2'd1,
    VERDICT_NEAR_KEPT = 2'd2,
    VERDICT_FULL      = 2'd3
  } verdict_e;

  typedef enum logic [8:0] {
    ST_IDLE       = 9'b000000001,
    ST_DISPATCH   = 9'b000000010,
    ST_SCAN       = 9'b000000100,
    ST_DRAIN      = 9'b000001000,
    ST_CHECK      = 9'b000010000,
    ST_FINISH     = 9'b000100000,
    ST_COPY       = 9'b001000000,
    ST_COPY_DRAIN = 9'b010000000,
    ST_EMIT       = 9'b100000000
  } state_e;

endpackage
`default_nettype wire

/* design/gisf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module gisf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* design/greedy_identity_sequence_filter_unit.sv */
// Top level of the greedy identity sequence filter.
// Depends on gisf_pkg and gisf_ram.
//
// Usage: residues stream in on the slave channel, one word each: tdata holds
// the residue, tuser the opcode (0 reference, 1 candidate), tlast ends a
// sequence. Words that do not end a sequence are taken back to back while
// the block is idle; up to MAX_SEQ_LEN words are buffered. At a last word
// the block drops tready and works on the sequence: a reference is copied
// into the reference store if it has room; a candidate is compared position
// by position against each stored reference and then each kept candidate
// (a store is skipped if its threshold is 65536 or more), one residue pair
// per cycle through a single compare-and-count unit, and a single
// multiplier checks matches*65536 > T*L at each row end (L the effective
// length). The walk stops at the first row that is too close. A kept
// candidate is then copied into the kept store. One result word per
// candidate leaves on the master channel through an output register; the
// block keeps taking residues while it waits, and only holds at the emit
// step of the next candidate if the receiver stalls. Reset empties both
// stores logically (counts to zero) with no clearing pass; registers return
// to 0.8 / 0.8 / 256. The APB port (pready tied high) must be written only
// while the block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module greedy_identity_sequence_filter_unit
  import gisf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave channel
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [4:0] residue, [7:5] zero
  input  wire logic        s_axis_tuser,   // [0] opcode
  input  wire logic        s_axis_tlast,
  // master channel
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [23:0] m_axis_tdata,   // [1:0] verdict, [12:2] kept_index,
                                           // [23:13] kept_total
  // APB configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  localparam int REF_AW  = $clog2(REF_DEPTH);
  localparam int KEPT_AW = $clog2(KEPT_DEPTH);

  // Configuration registers
  logic [THR_W-1:0] between_q, within_q;
  logic [SEQ_W-1:0] seq_len_q;
  logic             cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      between_q <= THR_RESET;
      within_q  <= THR_RESET;
      seq_len_q <= SEQ_RESET;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_BETWEEN: between_q <= pwdata[THR_W-1:0];
        REG_WITHIN:  within_q  <= pwdata[THR_W-1:0];
        REG_SEQ_LEN: seq_len_q <= pwdata[SEQ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_BETWEEN: prdata = 32'(between_q);
      REG_WITHIN:  prdata = 32'(within_q);
      REG_SEQ_LEN: prdata = 32'(seq_len_q);
      default:     prdata = '0;
    endcase
  end

  // Effective length: clamp to 1..MAX_SEQ_LEN
  logic [LEN_W-1:0] len_eff;
  always_comb begin
    if (seq_len_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(seq_len_q) > MAX_SEQ_LEN) begin
      len_eff = LEN_W'(MAX_SEQ_LEN);
    end else begin
      len_eff = LEN_W'(seq_len_q);
    end
  end

  // Sequencer state
  state_e                 state_q, state_d;
  logic [LEN_W-1:0]       in_pos_q, fill_q;
  logic                   is_cand_q;
  logic [CNT_W-1:0]       ref_cnt_q, kept_cnt_q;
  logic [CNT_W-1:0]       row_q;
  logic [POS_W-1:0]       pos_q;
  logic                   sel_kept_q;   // scanning the kept store
  logic                   dst_kept_q;   // copy target is the kept store
  logic                   scan_vld_q, copy_vld_q;
  logic [POS_W-1:0]       rpos_q;
  logic [MATCH_W-1:0]     match_q;
  logic [PROD_W-1:0]      prod_q;
  verdict_e               verdict_q;
  logic [CNT_W-1:0]       index_q;
  logic                   m_valid_q;
  logic [23:0]            m_data_q;

  logic in_acc;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Sequence buffer for references and candidates
  logic [RESIDUE_BITS-1:0] buf_rdata, buf_masked;
  logic                    buf_we;
  assign buf_we = in_acc && (32'(in_pos_q) < MAX_SEQ_LEN);

  gisf_ram #(.WIDTH(RESIDUE_BITS), .DEPTH(MAX_SEQ_LEN)) u_buf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (in_pos_q[POS_W-1:0]),
    .wdata_i (s_axis_tdata[RESIDUE_BITS-1:0]),
    .raddr_i (pos_q),
    .rdata_o (buf_rdata)
  );

  // Positions never supplied read as zero
  assign buf_masked = (LEN_W'(rpos_q) < fill_q) ? buf_rdata : '0;

  // Sequence stores
  logic [RESIDUE_BITS-1:0] ref_rdata, kept_rdata, row_data;
  logic                    ref_we, kept_we;
  logic [REF_AW-1:0]       ref_waddr, ref_raddr;
  logic [KEPT_AW-1:0]      kept_waddr, kept_raddr;

  assign ref_we     = copy_vld_q && !dst_kept_q;
  assign kept_we    = copy_vld_q && dst_kept_q;
  assign ref_waddr  = {ref_cnt_q[REF_ROW_W-1:0], rpos_q};
  assign kept_waddr = {kept_cnt_q[KEPT_ROW_W-1:0], rpos_q};
  assign ref_raddr  = {row_q[REF_ROW_W-1:0], pos_q};
  assign kept_raddr = {row_q[KEPT_ROW_W-1:0], pos_q};

  gisf_ram #(.WIDTH(RESIDUE_BITS), .DEPTH(REF_DEPTH)) u_ref_store (
    .clk_i   (clk_i),
    .we_i    (ref_we),
    .waddr_i (ref_waddr),
    .wdata_i (buf_masked),
    .raddr_i (ref_raddr),
    .rdata_o (ref_rdata)
  );

  gisf_ram #(.WIDTH(RESIDUE_BITS), .DEPTH(KEPT_DEPTH)) u_kept_store (
    .clk_i   (clk_i),
    .we_i    (kept_we),
    .waddr_i (kept_waddr),
    .wdata_i (buf_masked),
    .raddr_i (kept_raddr),
    .rdata_o (kept_rdata)
  );

  assign row_data = sel_kept_q ? kept_rdata : ref_rdata;

  // Shared compare unit and threshold product
  logic             row_near, ref_go, kept_go, row_more, out_free;
  logic [CNT_W-1:0] cur_cnt;
  logic [THR_W-1:0] thr_sel;

  assign thr_sel   = sel_kept_q ? within_q : between_q;
  assign row_near  = PROD_W'({match_q, 16'b0}) > prod_q;
  assign ref_go    = !between_q[THR_W-1] && (ref_cnt_q != '0);
  assign kept_go   = !within_q[THR_W-1] && (kept_cnt_q != '0);
  assign cur_cnt   = sel_kept_q ? kept_cnt_q : ref_cnt_q;
  assign row_more  = (row_q + CNT_W'(1)) < cur_cnt;
  assign out_free  = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:       if (in_acc && s_axis_tlast) state_d = ST_DISPATCH;
      ST_DISPATCH: begin
        if (is_cand_q == OP_REFERENCE) begin
          state_d = (32'(ref_cnt_q) < MAX_REFERENCES) ? ST_COPY : ST_IDLE;
        end else if (ref_go || kept_go) begin
          state_d = ST_SCAN;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_SCAN:       if (LEN_W'(pos_q) == len_eff - LEN_W'(1)) state_d = ST_DRAIN;
      ST_DRAIN:      state_d = ST_CHECK;
      ST_CHECK: begin
        if (row_near) begin
          state_d = ST_EMIT;
        end else if (row_more || (!sel_kept_q && kept_go)) begin
          state_d = ST_SCAN;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH:     state_d = (32'(kept_cnt_q) < MAX_KEPT) ? ST_COPY : ST_EMIT;
      ST_COPY:       if (pos_q == '1) state_d = ST_COPY_DRAIN;
      ST_COPY_DRAIN: state_d = is_cand_q ? ST_EMIT : ST_IDLE;
      ST_EMIT:       if (out_free) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      in_pos_q   <= '0;
      fill_q     <= '0;
      is_cand_q  <= 1'b0;
      ref_cnt_q  <= '0;
      kept_cnt_q <= '0;
      row_q      <= '0;
      pos_q      <= '0;
      sel_kept_q <= 1'b0;
      dst_kept_q <= 1'b0;
      scan_vld_q <= 1'b0;
      copy_vld_q <= 1'b0;
      rpos_q     <= '0;
      match_q    <= '0;
      verdict_q  <= VERDICT_KEPT;
      index_q    <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      scan_vld_q <= (state_q == ST_SCAN);
      copy_vld_q <= (state_q == ST_COPY);
      rpos_q     <= pos_q;
      // count matches one residue pair per cycle
      if (scan_vld_q && (row_data == buf_masked)) begin
        match_q <= match_q + MATCH_W'(1);
      end
      // load the output register at emit, drop the word once taken
      if ((state_q == ST_EMIT) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (s_axis_tlast) begin
              fill_q    <= (32'(in_pos_q) < MAX_SEQ_LEN) ? in_pos_q + LEN_W'(1)
                                                         : in_pos_q;
              in_pos_q  <= '0;
              is_cand_q <= s_axis_tuser;
            end else if (32'(in_pos_q) < MAX_SEQ_LEN) begin
              in_pos_q <= in_pos_q + LEN_W'(1);
            end
          end
        end
        ST_DISPATCH: begin
          pos_q      <= '0;
          row_q      <= '0;
          match_q    <= '0;
          sel_kept_q <= !ref_go;
          dst_kept_q <= 1'b0;
        end
        ST_SCAN: begin
          pos_q <= pos_q + POS_W'(1);
        end
        ST_CHECK: begin
          pos_q   <= '0;
          match_q <= '0;
          if (row_near) begin
            verdict_q <= sel_kept_q ? VERDICT_NEAR_KEPT : VERDICT_NEAR_REF;
            index_q   <= kept_cnt_q;
          end else if (row_more) begin
            row_q <= row_q + CNT_W'(1);
          end else begin
            row_q      <= '0;
            sel_kept_q <= 1'b1;
          end
        end
        ST_FINISH: begin
          pos_q      <= '0;
          dst_kept_q <= 1'b1;
          index_q    <= kept_cnt_q;
          verdict_q  <= (32'(kept_cnt_q) < MAX_KEPT) ? VERDICT_KEPT : VERDICT_FULL;
        end
        ST_COPY: begin
          pos_q <= pos_q + POS_W'(1);
        end
        ST_COPY_DRAIN: begin
          // commit the row once its last residue is written
          if (dst_kept_q) begin
            kept_cnt_q <= kept_cnt_q + CNT_W'(1);
          end else begin
            ref_cnt_q <= ref_cnt_q + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // One multiplier, registered before the compare
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(thr_sel) * PROD_W'(len_eff);
    if (state_q == ST_EMIT && out_free) begin
      m_data_q <= {kept_cnt_q, index_q, verdict_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule
`default_nettype wire

/* design/gisf_checker.sv */
// Port-level checker for the greedy identity sequence filter, bound to the top.
// Depends on gisf_pkg and greedy_identity_sequence_filter_unit_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "greedy_identity_sequence_filter_unit_macros.svh"
module gisf_checker
  import gisf_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        s_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata
);

  // hold a stalled result word
  `GISF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")

  // a finished sequence always takes the block busy
  `GISF_ASSERT_NEXT(a_busy_after_last, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready, "ready after last word")

  `GISF_ASSERT(a_total_range, !m_axis_tvalid || (m_axis_tdata[23:13] <= CNT_W'(MAX_KEPT)), "kept total out of range")

  `GISF_ASSERT(a_kept_count, !m_axis_tvalid || (m_axis_tdata[1:0] != VERDICT_KEPT) || (m_axis_tdata[23:13] == 11'(m_axis_tdata[12:2] + 11'd1)), "kept total mismatch")

  `GISF_ASSERT(a_reject_count, !m_axis_tvalid || (m_axis_tdata[1:0] == VERDICT_KEPT) || (m_axis_tdata[23:13] == m_axis_tdata[12:2]), "rejected total mismatch")

endmodule

bind greedy_identity_sequence_filter_unit gisf_checker u_gisf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

/* tb/tb_greedy_identity_sequence_filter_unit.sv */
// Testbench for greedy_identity_sequence_filter_unit: drives residue words,
// predicts each candidate verdict in a local model and checks result words.
// Depends on gisf_pkg and the design sources.
`timescale 1ns / 1ps
module tb_greedy_identity_sequence_filter_unit;
  import gisf_pkg::*;

  localparam int WATCHDOG_LIMIT = 100000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [4:0] residue, [7:5] zero
  logic        s_axis_tuser = 1'b0; // [0] opcode
  logic        s_axis_tlast = 1'b0;
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire  [23:0] m_axis_tdata;        // [1:0] verdict, [12:2] kept_index, [23:13] kept_total
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire  [31:0] prdata;
  wire         pready;

  greedy_identity_sequence_filter_unit u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // packed from the top bit down: kept_total, kept_index, verdict
  typedef struct packed {
    logic [CNT_W-1:0]  kept_total;
    logic [CNT_W-1:0]  kept_index;
    verdict_e          verdict;
  } verdict_word_t;

  typedef logic [RESIDUE_BITS-1:0] row_t [MAX_SEQ_LEN];

  // Local model of the filter
  row_t              refs_q[$];
  row_t              kept_q[$];
  row_t              cand_buf;
  int unsigned       cand_pos;
  logic [THR_W-1:0]  between_thr = THR_RESET;
  logic [THR_W-1:0]  within_thr = THR_RESET;
  logic [SEQ_W-1:0]  seq_len_reg = SEQ_RESET;
  verdict_word_t     verdicts_due[$];

  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_recv = 1'b0;
  int idle_cycles = 0;

  function automatic bit is_row_near(row_t row, int unsigned len, logic [THR_W-1:0] thr);
    longint unsigned hits;
    hits = 0;
    for (int n = 0; n < len; n++) if (row[n] == cand_buf[n]) hits++;
    return (hits << 16) > longint'(thr) * len;
  endfunction

  // Advance the model by one accepted word; queue a verdict when one is due
  function automatic void predict_word(logic op, logic [4:0] res, logic lst);
    int unsigned len;
    verdict_word_t w;
    if (cand_pos < MAX_SEQ_LEN) begin
      cand_buf[cand_pos] = res[RESIDUE_BITS-1:0];
      cand_pos++;
    end
    if (!lst) return;
    len = (seq_len_reg < 1) ? 1 : (seq_len_reg > MAX_SEQ_LEN ? MAX_SEQ_LEN : seq_len_reg);
    if (op == OP_REFERENCE) begin
      if (refs_q.size() < MAX_REFERENCES) refs_q.push_back(cand_buf);
    end else begin
      w.verdict = VERDICT_KEPT;
      if (between_thr < 17'd65536)
        foreach (refs_q[i])
          if (w.verdict == VERDICT_KEPT && is_row_near(refs_q[i], len, between_thr))
            w.verdict = VERDICT_NEAR_REF;
      if (w.verdict == VERDICT_KEPT && within_thr < 17'd65536)
        foreach (kept_q[i])
          if (w.verdict == VERDICT_KEPT && is_row_near(kept_q[i], len, within_thr))
            w.verdict = VERDICT_NEAR_KEPT;
      w.kept_index = CNT_W'(kept_q.size());
      if (w.verdict == VERDICT_KEPT) begin
        if (kept_q.size() < MAX_KEPT) kept_q.push_back(cand_buf);
        else w.verdict = VERDICT_FULL;
      end
      w.kept_total = CNT_W'(kept_q.size());
      verdicts_due.push_back(w);
    end
    foreach (cand_buf[i]) cand_buf[i] = '0;
    cand_pos = 0;
  endfunction

  // Offer one word and hold it until accepted; valid stays high afterwards
  task automatic send_word(logic op, logic [4:0] res, logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, res};
    s_axis_tuser  <= op;
    s_axis_tlast  <= lst;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_word(op, res, lst);
  endtask

  task automatic send_seq(logic op, row_t r, int unsigned n);
    for (int i = 0; i < n; i++) send_word(op, 5'(r[i]), i == n - 1);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_BETWEEN: between_thr = val[THR_W-1:0];
      REG_WITHIN:  within_thr = val[THR_W-1:0];
      default:     seq_len_reg = val[SEQ_W-1:0];
    endcase
    @(posedge clk_i);
  endtask

  // Drop valid, drain outstanding verdicts, then let any reference copy settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (MAX_SEQ_LEN + 20) @(posedge clk_i);
  endtask

  function automatic row_t rand_row();
    row_t r;
    foreach (r[i]) r[i] = RESIDUE_BITS'($urandom_range(31));
    return r;
  endfunction

  // Copy a row and mutate a few positions so identity lands near thresholds
  function automatic row_t mutate(row_t src, int unsigned len, int unsigned flips);
    row_t r;
    r = src;
    repeat (flips) r[$urandom_range(len - 1)] = RESIDUE_BITS'($urandom_range(31));
    return r;
  endfunction

  // Receiver: random ready, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else m_axis_tready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
  end

  // Check every accepted result word against the oldest prediction
  always @(posedge clk_i) begin
    verdict_word_t got, exp_w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (verdicts_due.size() == 0) begin
        $error("result word with no prediction waiting: %h", m_axis_tdata);
        errors++;
      end else begin
        exp_w = verdicts_due.pop_front();
        if (got.verdict !== exp_w.verdict) begin
          $error("verdict: expected %0d, got %0d", exp_w.verdict, got.verdict);
          errors++;
        end
        if (got.kept_index !== exp_w.kept_index) begin
          $error("kept_index: expected %0d, got %0d", exp_w.kept_index, got.kept_index);
          errors++;
        end
        if (got.kept_total !== exp_w.kept_total) begin
          $error("kept_total: expected %0d, got %0d", exp_w.kept_total, got.kept_total);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles with no accepted word on either channel
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Directed: extremes of residue and threshold, short sequences, length clamping
  task automatic test_directed();
    row_t a, z;
    a = rand_row();
    foreach (z[i]) z[i] = '0;
    write_reg(REG_SEQ_LEN, 32'd4);
    send_word(OP_REFERENCE, 5'd31, 1'b0);          // mixed opcodes: last decides
    send_word(OP_CANDIDATE, 5'd0, 1'b0);
    send_word(OP_REFERENCE, 5'd31, 1'b1);
    send_seq(OP_CANDIDATE, a, 4);
    send_seq(OP_CANDIDATE, a, 4);                   // near kept
    send_word(OP_CANDIDATE, 5'd31, 1'b1);           // short, zero padded
    send_seq(OP_CANDIDATE, z, 2);
    wait_idle();
    write_reg(REG_BETWEEN, 32'd0);
    write_reg(REG_WITHIN, 32'd65536);
    send_seq(OP_CANDIDATE, a, 4);
    wait_idle();
    write_reg(REG_BETWEEN, 32'd65536);
    write_reg(REG_WITHIN, 32'h1FFFF);
    write_reg(REG_SEQ_LEN, 32'd0);                  // clamps to 1
    send_seq(OP_CANDIDATE, a, 1);
    wait_idle();
    write_reg(REG_SEQ_LEN, 32'h1FF);                // clamps to max
    send_seq(OP_CANDIDATE, a, 1);
    wait_idle();
  endtask

  // Random: mostly candidates derived from earlier sent rows, some plain noise
  task automatic test_random(int unsigned words, int unsigned len_cfg);
    row_t pool[$];
    row_t r;
    int unsigned sent, n;
    sent = 0;
    write_reg(REG_SEQ_LEN, len_cfg);
    write_reg(REG_BETWEEN, $urandom_range(65536));
    write_reg(REG_WITHIN, $urandom_range(30000, 65536));
    while (sent < words) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(1, len_cfg + 2) : len_cfg;
      if (pool.size() != 0 && $urandom_range(3) != 0)
        r = mutate(pool[$urandom_range(pool.size() - 1)], len_cfg, $urandom_range(len_cfg));
      else r = rand_row();
      pool.push_back(r);
      send_seq($urandom_range(3) == 0 ? OP_REFERENCE : OP_CANDIDATE, r, n);
      sent += n;
    end
    wait_idle();
  endtask

  // Hold the receiver off so pending verdicts back up into the input
  task automatic test_backpressure();
    row_t r;
    hold_recv = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk_i);
        hold_recv = 1'b0;
      end
      begin
        repeat (6) begin
          r = rand_row();
          send_seq(OP_CANDIDATE, r, 3);
        end
        s_axis_tvalid <= 1'b0;
      end
    join
    wait_idle();
  endtask

  initial begin
    foreach (cand_buf[i]) cand_buf[i] = '0;
    cand_pos = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    send_idle_pct = 24; recv_idle_pct = 68;
    test_random(84, 5);
    send_idle_pct = 68; recv_idle_pct = 24;
    test_random(84, 3);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(84, 8);
    test_backpressure();
    repeat (100) @(posedge clk_i);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

/* sim.f */
+incdir+design
design/gisf_pkg.sv
design/gisf_ram.sv
design/greedy_identity_sequence_filter_unit.sv
design/gisf_checker.sv
tb/tb_greedy_identity_sequence_filter_unit.sv
